[design/rmsagc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmsagc_pkg
// Shared widths, register indexes and reset values of the block RMS AGC.
// ----------------------------------------------------------------------------
package rmsagc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int TARGET_W   = 15;
    localparam int RATE_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // defaults for the top-level parameters
    localparam int BLOCK_SAMPLES_DEF  = 64;
    localparam int GAIN_FRAC_BITS_DEF = 12;

    // shared shift-subtract unit and its partial remainder
    localparam int UNIT_W     = 19;
    localparam int REM_W      = 17;
    localparam int ROOT_W     = 16;
    localparam int ROOT_STEPS = 16;
    localparam int PROD_W     = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAIN     = 3'd4;

    // register reset values
    localparam logic [TARGET_W-1:0] TARGET_LEVEL_RST = 15'd8000;
    localparam logic [RATE_W-1:0]   ATTACK_RATE_RST  = 16'd32768;
    localparam logic [RATE_W-1:0]   RELEASE_RATE_RST = 16'd3277;
    localparam logic [GAIN_W-1:0]   MIN_GAIN_RST     = 16'd1024;
    localparam logic [GAIN_W-1:0]   MAX_GAIN_RST     = 16'd32768;

endpackage
`default_nettype wire

[design/rmsagc_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmsagc_in_if
// Sample request channel: valid/ready with one sample and its block-end flag.
// ----------------------------------------------------------------------------
interface rmsagc_in_if;
    import rmsagc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;

    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface
`default_nettype wire

[design/rmsagc_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmsagc_out_if
// Result request channel: valid/ready with one scaled sample and its flag.
// ----------------------------------------------------------------------------
interface rmsagc_out_if;
    import rmsagc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface
`default_nettype wire

[design/block_rms_agc_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// block_rms_agc_top
// Block RMS automatic gain control: stores a block of samples, derives the
// RMS and a smoothed gain with one shared shift-subtract unit and one shared
// multiplier, then streams the scaled block out.
// ----------------------------------------------------------------------------
// mid-block sample: stored on acceptance, squared, then accumulated
// block end: the sum is divided by the sample count, square-rooted and the
//   target divided by the root, bit-serially in the shared subtract unit,
//   then saturated, smoothed and clamped into the new gain; each result then
//   passes the store read port and multiplier while results are taken
// reset: control, sum, count and config registers return to their defaults,
//   gain to unity; the sample store needs no clearing and the block is ready
//   on the first cycle after reset
module block_rms_agc_top
    import rmsagc_pkg::*;
#(
    parameter int BLOCK_SAMPLES  = BLOCK_SAMPLES_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rmsagc_in_if.sink                              sample_ch,
    rmsagc_out_if.source                           result_ch,
    input  wire logic                              cfg_we,
    input  wire logic [rmsagc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rmsagc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rmsagc_pkg::*;

    localparam int CW     = $clog2(BLOCK_SAMPLES + 1);
    localparam int AW     = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int SUM_W  = 31 + $clog2(BLOCK_SAMPLES);
    localparam int WORK_W = (SUM_W > 32) ? SUM_W : 32;
    localparam int NUM_W  = TARGET_W + GAIN_FRAC_BITS;
    localparam int ITER_W = $clog2(WORK_W + 1);

    typedef enum logic [11:0] {
        ST_FILL = 12'b0000_0000_0001,
        ST_SQ   = 12'b0000_0000_0010,
        ST_ACC  = 12'b0000_0000_0100,
        ST_DIVN = 12'b0000_0000_1000,
        ST_SQRT = 12'b0000_0001_0000,
        ST_DIVG = 12'b0000_0010_0000,
        ST_SAT  = 12'b0000_0100_0000,
        ST_STEP = 12'b0000_1000_0000,
        ST_UPD  = 12'b0001_0000_0000,
        ST_RD   = 12'b0010_0000_0000,
        ST_MUL  = 12'b0100_0000_0000,
        ST_EMIT = 12'b1000_0000_0000
    } state_t;

    function automatic logic [SAMPLE_W-1:0] mag16(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] u;
        u = s;
        return s[SAMPLE_W-1] ? (~u + 16'd1) : u;
    endfunction

    // control registers
    state_t                state_reg,    state_next;
    logic [CW-1:0]         fill_cnt_reg, fill_cnt_next;
    logic [SUM_W-1:0]      sum_reg,      sum_next;
    logic                  acc_pend_reg, acc_pend_next;
    logic                  close_reg,    close_next;
    logic [ITER_W-1:0]     iter_reg,     iter_next;
    logic [AW-1:0]         rd_idx_reg,   rd_idx_next;
    logic [GAIN_W-1:0]     gain_reg,     gain_next;
    logic                  out_valid_reg, out_valid_next;

    // config registers
    logic [TARGET_W-1:0]   target_reg;
    logic [RATE_W-1:0]     attack_reg;
    logic [RATE_W-1:0]     release_reg;
    logic [GAIN_W-1:0]     min_gain_reg;
    logic [GAIN_W-1:0]     max_gain_reg;

    // datapath registers
    logic signed [SAMPLE_W-1:0] samp_reg,  samp_next;
    logic [WORK_W-1:0]     work_reg,     work_next;
    logic [REM_W-1:0]      rem_reg,      rem_next;
    logic [ROOT_W-1:0]     root_reg,     root_next;
    logic [PROD_W-1:0]     prod_reg,     prod_next;
    logic [GAIN_W-1:0]     diff_reg,     diff_next;
    logic                  dir_reg,      dir_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                  out_last_reg, out_last_next;
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic signed [SAMPLE_W-1:0] store_mem [BLOCK_SAMPLES];

    // shared units
    logic [UNIT_W-1:0]     au_a, au_b;
    logic [UNIT_W:0]       au_diff;
    logic                  au_ge;
    logic [SAMPLE_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]     mul_p;

    logic                  in_accept;
    logic                  out_free;
    logic [SUM_W-1:0]      acc_sum;
    logic [WORK_W-1:0]     div_shift;
    logic [ROOT_W-1:0]     root_step;
    logic [NUM_W-1:0]      numer;
    logic [GAIN_W-1:0]     desired;
    logic [GAIN_W:0]       gain_moved;
    logic [PROD_W-1:0]     scaled;
    logic                  last_elem;

    assign sample_ch.ready      = (state_reg == ST_FILL);
    assign in_accept            = sample_ch.valid && (state_reg == ST_FILL);
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_sample_reg;
    assign result_ch.last_out   = out_last_reg;
    assign out_free             = !out_valid_reg || result_ch.ready;

    // shift-subtract unit operands
    always_comb
    begin
        if (state_reg == ST_DIVN)
        begin
            au_a = UNIT_W'({rem_reg[CW-1:0], work_reg[WORK_W-1]});
            au_b = UNIT_W'(fill_cnt_reg);
        end
        else if (state_reg == ST_SQRT)
        begin
            au_a = {rem_reg, work_reg[WORK_W-1 -: 2]};
            au_b = UNIT_W'({root_reg, 2'b01});
        end
        else
        begin
            au_a = UNIT_W'({rem_reg[ROOT_W-1:0], work_reg[WORK_W-1]});
            au_b = UNIT_W'(root_reg);
        end
    end

    assign au_diff = {1'b0, au_a} - {1'b0, au_b};
    assign au_ge   = !au_diff[UNIT_W];

    // multiplier operands
    always_comb
    begin
        if (state_reg == ST_SQ)
        begin
            mul_a = mag16(samp_reg);
            mul_b = mag16(samp_reg);
        end
        else if (state_reg == ST_STEP)
        begin
            mul_a = dir_reg ? attack_reg : release_reg;
            mul_b = diff_reg;
        end
        else
        begin
            mul_a = mag16(rd_data_reg);
            mul_b = gain_reg;
        end
    end

    assign mul_p = mul_a * mul_b;

    assign acc_sum   = sum_reg + SUM_W'(prod_reg);
    assign div_shift = {work_reg[WORK_W-2:0], au_ge};
    assign root_step = {root_reg[ROOT_W-2:0], au_ge};
    assign numer     = {target_reg, GAIN_FRAC_BITS'(0)};
    assign desired   = (|work_reg[WORK_W-1:GAIN_W]) ? {GAIN_W{1'b1}} : work_reg[GAIN_W-1:0];
    assign gain_moved = dir_reg ? ({1'b0, gain_reg} - {1'b0, prod_reg[PROD_W-1 -: GAIN_W]})
                                : ({1'b0, gain_reg} + {1'b0, prod_reg[PROD_W-1 -: GAIN_W]});
    assign scaled    = prod_reg >> GAIN_FRAC_BITS;
    assign last_elem = (CW'(rd_idx_reg) + CW'(1)) == fill_cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_cnt_next   = fill_cnt_reg;
        sum_next        = sum_reg;
        acc_pend_next   = acc_pend_reg;
        close_next      = close_reg;
        iter_next       = iter_reg;
        rd_idx_next     = rd_idx_reg;
        gain_next       = gain_reg;
        out_valid_next  = out_valid_reg && !result_ch.ready;
        samp_next       = samp_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        prod_next       = prod_reg;
        diff_next       = diff_reg;
        dir_next        = dir_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_FILL:
            begin
                if (acc_pend_reg)
                begin
                    sum_next      = acc_sum;
                    acc_pend_next = 1'b0;
                end
                if (in_accept)
                begin
                    samp_next     = sample_ch.sample_in;
                    fill_cnt_next = fill_cnt_reg + CW'(1);
                    close_next    = sample_ch.last_in ||
                                    ((fill_cnt_reg + CW'(1)) == CW'(BLOCK_SAMPLES));
                    state_next    = ST_SQ;
                end
            end
            ST_SQ:
            begin
                prod_next     = mul_p;
                acc_pend_next = 1'b1;
                state_next    = close_reg ? ST_ACC : ST_FILL;
            end
            ST_ACC:
            begin
                // mean square: sum / n, dividend left-aligned in the work register
                work_next     = WORK_W'(acc_sum) << (WORK_W - SUM_W);
                sum_next      = '0;
                acc_pend_next = 1'b0;
                rem_next      = '0;
                iter_next     = ITER_W'(SUM_W);
                state_next    = ST_DIVN;
            end
            ST_DIVN:
            begin
                work_next = div_shift;
                rem_next  = au_ge ? REM_W'(au_diff) : REM_W'(au_a);
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    // radicand fits 32 bits, move it to the top for pairs
                    work_next  = div_shift << (WORK_W - 32);
                    rem_next   = '0;
                    root_next  = '0;
                    iter_next  = ITER_W'(ROOT_STEPS);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                work_next = work_reg << 2;
                rem_next  = au_ge ? REM_W'(au_diff) : REM_W'(au_a);
                root_next = root_step;
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    root_next  = (root_step == '0) ? ROOT_W'(1) : root_step;
                    work_next  = WORK_W'(numer) << (WORK_W - NUM_W);
                    rem_next   = '0;
                    iter_next  = ITER_W'(NUM_W);
                    state_next = ST_DIVG;
                end
            end
            ST_DIVG:
            begin
                work_next = div_shift;
                rem_next  = au_ge ? REM_W'(au_diff) : REM_W'(au_a);
                iter_next = iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                dir_next   = desired < gain_reg;
                diff_next  = (desired < gain_reg) ? (gain_reg - desired) : (desired - gain_reg);
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                prod_next  = mul_p;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // crossed clamps: a gain below the minimum takes the minimum, any other the maximum
                if (gain_moved[GAIN_W-1:0] < min_gain_reg)
                begin
                    gain_next = min_gain_reg;
                end
                else if (gain_moved[GAIN_W-1:0] > max_gain_reg)
                begin
                    gain_next = max_gain_reg;
                end
                else
                begin
                    gain_next = gain_moved[GAIN_W-1:0];
                end
                rd_idx_next = '0;
                state_next  = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = last_elem;
                    if (rd_data_reg[SAMPLE_W-1])
                    begin
                        out_sample_next = (scaled > 32'd32768) ? 16'sh8000
                                                               : $signed(~scaled[15:0] + 16'd1);
                    end
                    else
                    begin
                        out_sample_next = (scaled > 32'd32767) ? 16'sh7fff
                                                               : $signed(scaled[15:0]);
                    end
                    if (last_elem)
                    begin
                        fill_cnt_next = '0;
                        state_next    = ST_FILL;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_cnt_reg  <= '0;
            sum_reg       <= '0;
            acc_pend_reg  <= 1'b0;
            close_reg     <= 1'b0;
            iter_reg      <= '0;
            rd_idx_reg    <= '0;
            gain_reg      <= GAIN_W'(1 << GAIN_FRAC_BITS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            sum_reg       <= sum_next;
            acc_pend_reg  <= acc_pend_next;
            close_reg     <= close_next;
            iter_reg      <= iter_next;
            rd_idx_reg    <= rd_idx_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration writes, out-of-range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_LEVEL_RST;
            attack_reg   <= ATTACK_RATE_RST;
            release_reg  <= RELEASE_RATE_RST;
            min_gain_reg <= MIN_GAIN_RST;
            max_gain_reg <= MAX_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_LEVEL: target_reg   <= cfg_data[TARGET_W-1:0];
                REG_ATTACK_RATE:  attack_reg   <= cfg_data[RATE_W-1:0];
                REG_RELEASE_RATE: release_reg  <= cfg_data[RATE_W-1:0];
                REG_MIN_GAIN:     min_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_MAX_GAIN:     max_gain_reg <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg       <= samp_next;
        work_reg       <= work_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        prod_reg       <= prod_next;
        diff_reg       <= diff_next;
        dir_reg        <= dir_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            store_mem[fill_cnt_reg[AW-1:0]] <= sample_ch.sample_in;
        end
        rd_data_reg <= store_mem[rd_idx_reg];
    end

endmodule
`default_nettype wire

[design/rmsagc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rmsagc_checker
// Port-level checks of the block RMS AGC, bound to the top level.
// ----------------------------------------------------------------------------
module rmsagc_checker
    import rmsagc_pkg::*;
(
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  in_valid,
    input wire logic                                  in_ready,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic signed [rmsagc_pkg::SAMPLE_W-1:0] out_sample,
    input wire logic                                  out_last
);
    import rmsagc_pkg::*;

    // a pending result is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before it was taken");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
        else $error("stalled result payload changed");

    // no new sample is taken while a block is still being drained
    a_no_input_mid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("sample taken while block results are still pending");

    // every accepted sample is followed by ready going low
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after a sample was accepted");

endmodule

bind block_rms_agc_top rmsagc_checker u_rmsagc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_sample (result_ch.sample_out),
    .out_last   (result_ch.last_out)
);
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Block RMS AGC check: feeds sample requests with random gaps and result
// stalls, predicts the gain update and scaled output of every closed block,
// and compares each result request field by field with that prediction.
// ----------------------------------------------------------------------------
module testbench;
    import rmsagc_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int BLOCK_LEN     = BLOCK_SAMPLES_DEF;
    localparam int FRAC_BITS     = GAIN_FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS  = 170;
    localparam int PHASE_ITEMS   = 55;
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RUN_LIMIT_NS  = 4_000_000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_MAX_GAIN + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] scaled;
        logic                last_flag;
    } scaled_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rmsagc_in_if  sample_ch ();
    rmsagc_out_if result_ch ();

    block_rms_agc_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of registers and block state
    logic [TARGET_W-1:0]        cfg_target;
    logic [RATE_W-1:0]          cfg_attack;
    logic [RATE_W-1:0]          cfg_release;
    logic [GAIN_W-1:0]          cfg_min;
    logic [GAIN_W-1:0]          cfg_max;
    logic signed [SAMPLE_W-1:0] held_block [BLOCK_LEN];
    logic [36:0]                block_energy;
    logic [6:0]                 block_fill;
    logic [GAIN_W-1:0]          gain_held;

    scaled_result_t expected_scaled [$];

    bit          calm = 1'b0;
    int unsigned samples_sent = 0;
    int unsigned random_items = 0;
    int unsigned blocks_closed = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned drain_timeouts = 0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // rms of the closed block, desired gain, smoothing step, then the clamps
    function automatic void retune_gain(int unsigned count);
        longint unsigned mean;
        longint unsigned rms;
        longint unsigned desired;
        longint unsigned gain;
        longint unsigned step;
        mean = 64'(block_energy) / 64'(count);
        rms  = floor_root(mean);
        if (rms == 0)
            rms = 1;
        desired = (64'(cfg_target) << FRAC_BITS) / rms;
        if (desired > 65535)
            desired = 65535;
        gain = 64'(gain_held);
        if (desired < gain)
        begin
            step = (64'(cfg_attack) * (gain - desired)) >> 16;
            gain = gain - step;
        end
        else
        begin
            step = (64'(cfg_release) * (desired - gain)) >> 16;
            gain = gain + step;
        end
        // crossed clamps: below the minimum takes the minimum, any other the maximum
        if (gain < 64'(cfg_min))
            gain = 64'(cfg_min);
        else if (gain > 64'(cfg_max))
            gain = 64'(cfg_max);
        gain_held = gain[GAIN_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] scaled_sample(logic signed [SAMPLE_W-1:0] s);
        longint          wide;
        longint unsigned mag;
        longint unsigned prod;
        wide = s;
        mag  = (wide < 0) ? -wide : wide;
        prod = (mag * 64'(gain_held)) >> FRAC_BITS;
        if (wide < 0)
        begin
            if (prod > 32768)
                prod = 32768;
            prod = -prod;
        end
        else if (prod > 32767)
            prod = 32767;
        return prod[SAMPLE_W-1:0];
    endfunction

    function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] s, logic closes);
        longint         wide;
        scaled_result_t res;
        int unsigned    i;
        wide = s;
        held_block[block_fill] = s;
        block_energy = block_energy + 37'(wide * wide);
        block_fill = block_fill + 1'b1;
        if (closes || block_fill >= BLOCK_LEN)
        begin
            retune_gain(block_fill);
            for (i = 0; i < block_fill; i++)
            begin
                res.scaled    = scaled_sample(held_block[i]);
                res.last_flag = (i + 1 == block_fill);
                expected_scaled.push_back(res);
            end
            block_energy = '0;
            block_fill   = '0;
            blocks_closed++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level(int unsigned lo, int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return CFG_DATA_W'(lo);
        if (roll < 40)
            return CFG_DATA_W'(hi);
        return CFG_DATA_W'($urandom_range(lo, hi));
    endfunction

    function automatic void note_mismatch(string field, int want, int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_TARGET_LEVEL: cfg_target  = data[TARGET_W-1:0];
            REG_ATTACK_RATE:  cfg_attack  = data[RATE_W-1:0];
            REG_RELEASE_RATE: cfg_release = data[RATE_W-1:0];
            REG_MIN_GAIN:     cfg_min     = data[GAIN_W-1:0];
            REG_MAX_GAIN:     cfg_max     = data[GAIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // valid stays high after acceptance so back-to-back requests need no gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic closes);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid     = 1'b1;
        sample_ch.sample_in = s;
        sample_ch.last_in   = closes;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        absorb_sample(s, closes);
        samples_sent++;
    endtask

    task automatic send_block(input int unsigned len, input int unsigned shift,
                              input logic closes_last);
        logic signed [SAMPLE_W-1:0] s;
        for (int unsigned i = 0; i < len; i++)
        begin
            s = SAMPLE_W'($urandom);
            s = s >>> shift;
            send_sample(s, (i + 1 == len) ? closes_last : 1'b0);
        end
    endtask

    // drop valid, wait for every owed result, then let the sequencer go quiet
    task automatic settle();
        int unsigned waited;
        @(negedge clk);
        sample_ch.valid = 1'b0;
        waited = 0;
        while (expected_scaled.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_scaled.size() != 0)
        begin
            drain_timeouts++;
            $display("results still owed after drain: %0d", expected_scaled.size());
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        send_sample(16'sd250, 1'b1);
        settle();
    endtask

    task automatic test_field_extremes();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);
        settle();
    endtask

    task automatic test_forced_close();
        send_block(BLOCK_LEN, 0, 1'b0);
        send_sample(-16'sd12345, 1'b1);
        send_block(BLOCK_LEN, 4, 1'b1);
        settle();
    endtask

    task automatic test_register_masking();
        // bit 15 of the target must fall away
        write_reg(REG_TARGET_LEVEL, 16'hFFFF);
        write_reg(REG_SPARE_FIRST, 16'hFFFF);
        write_reg(REG_SPARE_LAST, 16'h0000);
        send_sample(16'sd9000, 1'b0);
        send_sample(-16'sd9000, 1'b0);
        send_sample(16'sd4500, 1'b0);
        send_sample(16'sd1, 1'b1);
        settle();
    endtask

    task automatic test_output_saturation();
        // quiet block pulls the gain near its ceiling, attack 0 keeps it there
        write_reg(REG_ATTACK_RATE, 16'h0000);
        write_reg(REG_RELEASE_RATE, 16'hFFFF);
        write_reg(REG_MAX_GAIN, 16'hFFFF);
        send_sample(16'sd2, 1'b0);
        send_sample(-16'sd2, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd20000, 1'b0);
        send_sample(-16'sd20000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        settle();
    endtask

    task automatic test_zero_target();
        write_reg(REG_MIN_GAIN, 16'h0000);
        write_reg(REG_ATTACK_RATE, 16'hFFFF);
        write_reg(REG_TARGET_LEVEL, 16'h0000);
        send_sample(16'sd5000, 1'b0);
        send_sample(-16'sd7000, 1'b1);
        send_sample(16'sd123, 1'b0);
        send_sample(-16'sd456, 1'b0);
        send_sample(16'sd789, 1'b1);
        settle();
    endtask

    task automatic test_crossed_clamps();
        write_reg(REG_TARGET_LEVEL, 16'd8000);
        write_reg(REG_MIN_GAIN, 16'd40000);
        write_reg(REG_MAX_GAIN, 16'd2000);
        send_sample(16'sd10000, 1'b0);
        send_sample(-16'sd10000, 1'b1);
        settle();
        write_reg(REG_MIN_GAIN, 16'h0000);
        write_reg(REG_MAX_GAIN, 16'h0000);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned       phase;
        int unsigned       phase_items;
        int unsigned       len;
        int unsigned       shift;
        int unsigned       roll;
        logic [GAIN_W-1:0] lo;
        logic [GAIN_W-1:0] hi;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            calm = (phase % 4 == 2);
            write_reg(REG_TARGET_LEVEL, pick_level(1, 32767));
            write_reg(REG_ATTACK_RATE, pick_level(0, 65535));
            write_reg(REG_RELEASE_RATE, pick_level(0, 65535));
            lo = pick_level(0, 8192);
            hi = pick_level(2048, 65535);
            if ($urandom_range(9) == 0)
                {lo, hi} = {hi, lo};
            write_reg(REG_MIN_GAIN, lo);
            write_reg(REG_MAX_GAIN, hi);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                if (roll < 65)
                    len = $urandom_range(1, 12);
                else if (roll < 88)
                    len = $urandom_range(13, BLOCK_LEN - 1);
                else
                    len = BLOCK_LEN;
                // loud blocks often, otherwise anything down to near silence
                shift = ($urandom_range(9) < 3) ? 0 : $urandom_range(0, 15);
                send_block(len, shift, (len < BLOCK_LEN) ? 1'b1 : 1'($urandom_range(1)));
                phase_items += len;
                random_items += len;
            end
            phase++;
        end
        calm = 1'b0;
        settle();
    endtask

    // result side stalls
    initial
    begin
        int unsigned stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall != 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap();
                result_ch.ready = (stall == 0);
                if (stall != 0)
                    stall--;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        scaled_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_checked++;
            if (expected_scaled.size() == 0)
                note_mismatch("unexpected sample_out", 0, result_ch.sample_out);
            else
            begin
                want = expected_scaled.pop_front();
                if (result_ch.sample_out !== want.scaled)
                    note_mismatch("sample_out", $signed(want.scaled), result_ch.sample_out);
                if (result_ch.last_out !== want.last_flag)
                    note_mismatch("last_out", want.last_flag, result_ch.last_out);
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_TARGET_LEVEL;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        sample_ch.last_in   = 1'b0;
        cfg_target          = TARGET_LEVEL_RST;
        cfg_attack          = ATTACK_RATE_RST;
        cfg_release         = RELEASE_RATE_RST;
        cfg_min             = MIN_GAIN_RST;
        cfg_max             = MAX_GAIN_RST;
        block_energy        = '0;
        block_fill          = '0;
        gain_held           = GAIN_W'(1) << FRAC_BITS;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_field_extremes();
        test_forced_close();
        test_register_masking();
        test_output_saturation();
        test_zero_target();
        test_crossed_clamps();
        test_random_traffic();
        settle();

        $display("run covered %0d samples (%0d random) in %0d blocks, %0d register writes",
                 samples_sent, random_items, blocks_closed, reg_writes);
        $display("%0d scaled results checked, %0d mismatches, %0d results owed",
                 results_checked, mismatches, expected_scaled.size());
        if (mismatches == 0 && drain_timeouts == 0 && expected_scaled.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("run limit reached");
        $display("FAILURE");
        $finish;
    end

endmodule
